@@ src/rmms_pkg.sv @@
package rmms_pkg;

  localparam int SMP_W  = 32;
  localparam int CNT_W  = 32;
  localparam int M2_W   = 64;
  localparam int STD_W  = 31;
  localparam int ALU_W  = 66;
  localparam int MAG_W  = SMP_W + 1;
  localparam int STEP_W = 7;

  localparam logic [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
  localparam logic [CNT_W-1:0] CNT_FULL = {CNT_W{1'b1}};

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

endpackage

@@ src/rmms_alu.sv @@
module rmms_alu
  import rmms_pkg::*;
(
  input  alu_req_t         req,
  output logic [ALU_W-1:0] res
);

  logic [ALU_W-1:0] b_eff;

  assign b_eff = req.sub ? ~req.b : req.b;
  assign res   = req.a + b_eff + {{(ALU_W-1){1'b0}}, req.sub};

endmodule

@@ src/running_min_max_mean_stdev.sv @@
// Running min / max / mean / sample standard deviation over Q15.16 samples.
// Input beat: in_kind (0 = sample, 1 = clear), in_sample, in_sample_invalid.
// Every input beat yields exactly one output beat with min, max, mean,
// std_dev, sample_count and the flags stats_valid, spread_valid, saturated.
// One shared 66-bit add/subtract unit does all arithmetic under a sequencer.
// A valid sample runs: delta, magnitude, 33-step divide (mean update),
// 33-step shift-add multiply, accumulate, and with two or more samples a
// 64-step divide m2/(n-1) and a 32-step square root before the result.
// Clear, invalid or ignored (count full) beats go straight to the output step.
// in_stall is high while an item is being processed; one item at a time.
// The next beat is accepted in the cycle after the result is loaded, so
// a new valid sample is never started before the last one is through.
// The result sits in an output register; the next input is accepted while it
// waits, and a finished result waits for the register to drain while
// out_stall is high. Synchronous active-low reset restores empty statistics
// and drops any pending result.
module running_min_max_mean_stdev
  import rmms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [SMP_W-1:0]  in_sample,
  input  logic              in_sample_invalid,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SMP_W-1:0]  out_minimum,
  output logic [SMP_W-1:0]  out_maximum,
  output logic [SMP_W-1:0]  out_average,
  output logic [STD_W-1:0]  out_std_dev,
  output logic [CNT_W-1:0]  out_sample_count,
  output logic              out_stats_valid,
  output logic              out_spread_valid,
  output logic              out_saturated
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DELTA, ST_DMAG, ST_DIV1, ST_QNEG, ST_MEAN, ST_MAG2,
    ST_MUL, ST_ACC, ST_DIVP, ST_DIV2, ST_SQRT, ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic signed [SMP_W-1:0] min_r, min_nxt, max_r, max_nxt, mean_r, mean_nxt, x_r, x_nxt;
  logic [M2_W-1:0]  m2_r, m2_nxt, q_r, q_nxt, acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, div_r, div_nxt;
  logic             sat_r, sat_nxt, neg_r, neg_nxt;
  logic [STD_W-1:0] std_r, std_nxt;
  logic [MAG_W-1:0] mag1_r, mag1_nxt, mag2_r, mag2_nxt;
  logic [34:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0] root_r, root_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [SMP_W-1:0] o_min_r, o_min_nxt, o_max_r, o_max_nxt, o_avg_r, o_avg_nxt;
  logic [STD_W-1:0] o_std_r, o_std_nxt;
  logic [CNT_W-1:0] o_cnt_r, o_cnt_nxt;
  logic             o_sv_r, o_sv_nxt, o_pv_r, o_pv_nxt, o_sat_r, o_sat_nxt;

  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_res;

  rmms_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  logic [33:0] div_shift;
  logic [34:0] sqrt_shift;
  logic [CNT_W-1:0] cnt_inc;

  assign div_shift  = {rem_r[32:0], q_r[M2_W-1]};
  assign sqrt_shift = {rem_r[32:0], q_r[M2_W-1:M2_W-2]};
  assign cnt_inc    = cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};

  always_comb begin
    alu_req = '0;
    unique case (state_r)
      ST_DELTA: begin
        alu_req.a   = {{(ALU_W-SMP_W){x_r[SMP_W-1]}}, x_r};
        alu_req.b   = {{(ALU_W-SMP_W){mean_r[SMP_W-1]}}, mean_r};
        alu_req.sub = 1'b1;
      end
      ST_DMAG: begin
        alu_req.b   = {{(ALU_W-M2_W){acc_r[M2_W-1]}}, acc_r};
        alu_req.sub = 1'b1;
      end
      ST_DIV1, ST_DIV2: begin
        alu_req.a   = {{(ALU_W-34){1'b0}}, div_shift};
        alu_req.b   = {{(ALU_W-CNT_W){1'b0}}, div_r};
        alu_req.sub = 1'b1;
      end
      ST_QNEG: begin
        alu_req.b   = {{(ALU_W-MAG_W){1'b0}}, q_r[MAG_W-1:0]};
        alu_req.sub = 1'b1;
      end
      ST_MEAN: begin
        alu_req.a = {{(ALU_W-SMP_W){mean_r[SMP_W-1]}}, mean_r};
        alu_req.b = {{(ALU_W-M2_W){acc_r[M2_W-1]}}, acc_r};
      end
      ST_MAG2: begin
        alu_req.a   = {{(ALU_W-MAG_W){1'b0}}, mag1_r};
        alu_req.b   = {{(ALU_W-MAG_W){1'b0}}, q_r[MAG_W-1:0]};
        alu_req.sub = 1'b1;
      end
      ST_MUL: begin
        alu_req.a = {{(ALU_W-M2_W){1'b0}}, acc_r[M2_W-2:0], 1'b0};
        alu_req.b = mag2_r[MAG_W-1] ? {{(ALU_W-MAG_W){1'b0}}, mag1_r} : '0;
      end
      ST_ACC: begin
        alu_req.a = {{(ALU_W-M2_W){1'b0}}, m2_r};
        alu_req.b = {{(ALU_W-M2_W){1'b0}}, acc_r};
      end
      ST_DIVP: begin
        alu_req.a   = {{(ALU_W-CNT_W){1'b0}}, cnt_r};
        alu_req.b   = {{(ALU_W-1){1'b0}}, 1'b1};
        alu_req.sub = 1'b1;
      end
      ST_SQRT: begin
        alu_req.a   = {{(ALU_W-35){1'b0}}, sqrt_shift};
        alu_req.b   = {{(ALU_W-CNT_W-2){1'b0}}, root_r, 2'b01};
        alu_req.sub = 1'b1;
      end
      default: alu_req = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    min_nxt = min_r; max_nxt = max_r; mean_nxt = mean_r; x_nxt = x_r;
    m2_nxt = m2_r; q_nxt = q_r; acc_nxt = acc_r; cnt_nxt = cnt_r; div_nxt = div_r;
    sat_nxt = sat_r; neg_nxt = neg_r; std_nxt = std_r;
    mag1_nxt = mag1_r; mag2_nxt = mag2_r; rem_nxt = rem_r; root_nxt = root_r;
    step_nxt = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_min_nxt = o_min_r; o_max_nxt = o_max_r; o_avg_nxt = o_avg_r; o_std_nxt = o_std_r;
    o_cnt_nxt = o_cnt_r; o_sv_nxt = o_sv_r; o_pv_nxt = o_pv_r; o_sat_nxt = o_sat_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_sample;
          state_nxt = ST_OUT;
          if (in_kind) begin
            min_nxt = SMP_MAX; max_nxt = SMP_MIN; mean_nxt = '0; m2_nxt = '0;
            cnt_nxt = '0; sat_nxt = 1'b0; std_nxt = '0;
          end else if (!in_sample_invalid && cnt_r != CNT_FULL) begin
            state_nxt = ST_DELTA;
          end
        end
      end
      ST_DELTA: begin
        if (x_r < min_r) min_nxt = x_r;
        if (x_r > max_r) max_nxt = x_r;
        cnt_nxt = cnt_inc;
        div_nxt = cnt_inc;
        if (cnt_inc == CNT_FULL) sat_nxt = 1'b1;
        acc_nxt   = {{(M2_W-MAG_W){alu_res[MAG_W-1]}}, alu_res[MAG_W-1:0]};
        neg_nxt   = alu_res[MAG_W-1];
        state_nxt = ST_DMAG;
      end
      ST_DMAG: begin
        mag1_nxt  = neg_r ? alu_res[MAG_W-1:0] : acc_r[MAG_W-1:0];
        q_nxt     = {(neg_r ? alu_res[MAG_W-1:0] : acc_r[MAG_W-1:0]),
                     {(M2_W-MAG_W){1'b0}}};
        rem_nxt   = '0;
        step_nxt  = STEP_W'(MAG_W);
        state_nxt = ST_DIV1;
      end
      ST_DIV1, ST_DIV2: begin
        if (alu_res[ALU_W-1]) begin
          rem_nxt = {1'b0, div_shift};
          q_nxt   = {q_r[M2_W-2:0], 1'b0};
        end else begin
          rem_nxt = alu_res[34:0];
          q_nxt   = {q_r[M2_W-2:0], 1'b1};
        end
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          if (state_r == ST_DIV1) begin
            state_nxt = ST_QNEG;
          end else begin
            rem_nxt   = '0;
            root_nxt  = '0;
            step_nxt  = STEP_W'(M2_W / 2);
            state_nxt = ST_SQRT;
          end
        end
      end
      ST_QNEG: begin
        acc_nxt   = neg_r ? alu_res[M2_W-1:0] : {{(M2_W-MAG_W){1'b0}}, q_r[MAG_W-1:0]};
        state_nxt = ST_MEAN;
      end
      ST_MEAN: begin
        mean_nxt  = alu_res[SMP_W-1:0];
        state_nxt = ST_MAG2;
      end
      ST_MAG2: begin
        mag2_nxt  = alu_res[MAG_W-1:0];
        acc_nxt   = '0;
        step_nxt  = STEP_W'(MAG_W);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        acc_nxt  = alu_res[M2_W-1:0];
        mag2_nxt = {mag2_r[MAG_W-2:0], 1'b0};
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(1)) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (alu_res[M2_W]) begin
          m2_nxt  = {M2_W{1'b1}};
          sat_nxt = 1'b1;
        end else begin
          m2_nxt = alu_res[M2_W-1:0];
        end
        q_nxt     = alu_res[M2_W] ? {M2_W{1'b1}} : alu_res[M2_W-1:0];
        state_nxt = (cnt_r >= CNT_W'(2)) ? ST_DIVP : ST_OUT;
      end
      ST_DIVP: begin
        div_nxt   = alu_res[CNT_W-1:0];
        rem_nxt   = '0;
        step_nxt  = STEP_W'(M2_W);
        state_nxt = ST_DIV2;
      end
      ST_SQRT: begin
        if (alu_res[ALU_W-1]) begin
          rem_nxt  = sqrt_shift;
          root_nxt = {root_r[CNT_W-2:0], 1'b0};
        end else begin
          rem_nxt  = alu_res[34:0];
          root_nxt = {root_r[CNT_W-2:0], 1'b1};
        end
        q_nxt    = {q_r[M2_W-3:0], 2'b00};
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          std_nxt   = root_nxt[CNT_W-1] ? {STD_W{1'b1}} : root_nxt[STD_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          o_sv_nxt  = cnt_r != '0;
          o_pv_nxt  = cnt_r >= CNT_W'(2);
          o_min_nxt = (cnt_r != '0) ? min_r : '0;
          o_max_nxt = (cnt_r != '0) ? max_r : '0;
          o_avg_nxt = (cnt_r != '0) ? mean_r : '0;
          o_std_nxt = std_r;
          o_cnt_nxt = cnt_r;
          o_sat_nxt = sat_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      min_r <= SMP_MAX; max_r <= SMP_MIN; mean_r <= '0; m2_r <= '0;
      cnt_r <= '0; sat_r <= 1'b0; std_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      min_r <= min_nxt; max_r <= max_nxt; mean_r <= mean_nxt; m2_r <= m2_nxt;
      cnt_r <= cnt_nxt; sat_r <= sat_nxt; std_r <= std_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r <= x_nxt; q_r <= q_nxt; acc_r <= acc_nxt; div_r <= div_nxt; neg_r <= neg_nxt;
    mag1_r <= mag1_nxt; mag2_r <= mag2_nxt; rem_r <= rem_nxt; root_r <= root_nxt;
    step_r <= step_nxt;
    o_min_r <= o_min_nxt; o_max_r <= o_max_nxt; o_avg_r <= o_avg_nxt; o_std_r <= o_std_nxt;
    o_cnt_r <= o_cnt_nxt; o_sv_r <= o_sv_nxt; o_pv_r <= o_pv_nxt; o_sat_r <= o_sat_nxt;
  end

  assign in_stall         = state_r != ST_IDLE;
  assign out_valid        = out_valid_r;
  assign out_minimum      = o_min_r;
  assign out_maximum      = o_max_r;
  assign out_average      = o_avg_r;
  assign out_std_dev      = o_std_r;
  assign out_sample_count = o_cnt_r;
  assign out_stats_valid  = o_sv_r;
  assign out_spread_valid = o_pv_r;
  assign out_saturated    = o_sat_r;

  a_std_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(2) |-> std_r == '0) else $error("std_dev set with fewer than two samples");
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 |-> min_r <= max_r) else $error("minimum above maximum");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV2 |-> cnt_r >= CNT_W'(2)) else $error("divide by zero count");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_pv_r |-> o_sv_r) else $error("spread valid without stats valid");

endmodule

@@ verif/tb_running_min_max_mean_stdev.sv @@
`timescale 1ns / 1ps

module tb_running_min_max_mean_stdev;
  import rmms_pkg::*;

  localparam int N_RANDOM = 1525;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 3000;
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic [SMP_W-1:0] minimum;
    logic [SMP_W-1:0] maximum;
    logic [SMP_W-1:0] average;
    logic [STD_W-1:0] std_dev;
    logic [CNT_W-1:0] sample_count;
    logic             stats_valid;
    logic             spread_valid;
    logic             saturated;
  } stats_report_t;

  class stats_scoreboard;
    longint lo_seen;
    longint hi_seen;
    longint mean_acc;
    longint unsigned m2_acc;
    longint unsigned n_acc;
    bit sat_acc;
    stats_report_t reports_due[$];
    int fails;

    function new();
      fails = 0;
      clear_stats();
    endfunction

    function void clear_stats();
      lo_seen = 64'sd2147483647;
      hi_seen = -64'sd2147483648;
      mean_acc = 0;
      m2_acc = 0;
      n_acc = 0;
      sat_acc = 0;
    endfunction

    function longint unsigned magnitude(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
        if (v >= root + probe) begin
          v = v - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      return root;
    endfunction

    function void note_input(logic kind, logic [SMP_W-1:0] smp, logic inv);
      longint x;
      longint d;
      longint d2;
      longint unsigned prod;
      longint unsigned total;
      longint unsigned root;
      stats_report_t r;
      root = 0;
      if (kind == KIND_CLEAR) begin
        clear_stats();
      end else if (!inv && n_acc < 64'hFFFF_FFFF) begin
        x = longint'($signed(smp));
        if (x < lo_seen) lo_seen = x;
        if (x > hi_seen) hi_seen = x;
        n_acc++;
        if (n_acc == 64'hFFFF_FFFF) sat_acc = 1;
        d = x - mean_acc;
        mean_acc = mean_acc + d / longint'(n_acc);
        d2 = x - mean_acc;
        prod = magnitude(d) * magnitude(d2);
        total = m2_acc + prod;
        if (total < m2_acc) begin
          total = '1;
          sat_acc = 1;
        end
        m2_acc = total;
      end
      if (n_acc >= 2) begin
        root = int_sqrt(m2_acc / (n_acc - 1));
        if (root > 64'h7FFF_FFFF) root = 64'h7FFF_FFFF;
      end
      r.minimum = n_acc >= 1 ? lo_seen[31:0] : '0;
      r.maximum = n_acc >= 1 ? hi_seen[31:0] : '0;
      r.average = n_acc >= 1 ? mean_acc[31:0] : '0;
      r.std_dev = root[STD_W-1:0];
      r.sample_count = n_acc[31:0];
      r.stats_valid = n_acc >= 1;
      r.spread_valid = n_acc >= 2;
      r.saturated = sat_acc;
      reports_due.push_back(r);
    endfunction

    function void field_cmp(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        fails++;
        if (fails <= 10)
          $display("%0t %s: expected %0h actual %0h", $realtime, name, want, got);
      end
    endfunction

    function void check_report(stats_report_t got);
      stats_report_t want;
      if (reports_due.size() == 0) begin
        fails++;
        if (fails <= 10) $display("%0t unexpected output beat", $realtime);
        return;
      end
      want = reports_due.pop_front();
      field_cmp("minimum", 64'(want.minimum), 64'(got.minimum));
      field_cmp("maximum", 64'(want.maximum), 64'(got.maximum));
      field_cmp("average", 64'(want.average), 64'(got.average));
      field_cmp("std_dev", 64'(want.std_dev), 64'(got.std_dev));
      field_cmp("sample_count", 64'(want.sample_count), 64'(got.sample_count));
      field_cmp("stats_valid", 64'(want.stats_valid), 64'(got.stats_valid));
      field_cmp("spread_valid", 64'(want.spread_valid), 64'(got.spread_valid));
      field_cmp("saturated", 64'(want.saturated), 64'(got.saturated));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_kind;
  logic [SMP_W-1:0] in_sample;
  logic in_sample_invalid;
  logic out_valid;
  logic out_stall;
  logic [SMP_W-1:0] out_minimum;
  logic [SMP_W-1:0] out_maximum;
  logic [SMP_W-1:0] out_average;
  logic [STD_W-1:0] out_std_dev;
  logic [CNT_W-1:0] out_sample_count;
  logic out_stats_valid;
  logic out_spread_valid;
  logic out_saturated;

  stats_scoreboard sb = new();
  bit calm = 0;
  bit hold_req = 0;
  int cycles = 0;

  running_min_max_mean_stdev i_dut (.*);

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_report({out_minimum, out_maximum, out_average, out_std_dev,
                       out_sample_count, out_stats_valid, out_spread_valid,
                       out_saturated});
  end

  initial begin
    int left;
    out_stall = 0;
    left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (left > 0) begin
        left--;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        left = $urandom_range(0, 16);
      end
    end
  end

  task automatic send_beat(logic kind, logic [SMP_W-1:0] smp, logic inv);
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_sample <= smp;
    in_sample_invalid <= inv;
    do @(posedge clk); while (in_stall);
    sb.note_input(kind, smp, inv);
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_sample <= $urandom;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.reports_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($signed($urandom_range(0, 40000)) - 20000) <<< 8;
      4, 5, 6: return $urandom;
      7: return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
      default: return 32'($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  initial begin
    int k;
    in_valid = 0;
    in_kind = KIND_SAMPLE;
    in_sample = '0;
    in_sample_invalid = 0;
    rst_n = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_beat(KIND_SAMPLE, 32'h1234_0000, 1'b1);
    send_beat(KIND_SAMPLE, '0, 1'b0);
    send_beat(KIND_SAMPLE, 32'h7FFF_0000, 1'b1);
    send_beat(KIND_SAMPLE, SMP_MAX, 1'b0);
    send_beat(KIND_SAMPLE, SMP_MIN, 1'b0);
    send_beat(KIND_SAMPLE, 32'h0000_0001, 1'b0);
    send_beat(KIND_SAMPLE, 32'hFFFF_FFFF, 1'b0);
    send_beat(KIND_CLEAR, '0, 1'b0);
    send_beat(KIND_SAMPLE, 32'h0001_0000, 1'b0);
    send_beat(KIND_CLEAR, 32'hFFFF_FFFF, 1'b1);
    for (k = 0; k < 12; k++) send_beat(KIND_SAMPLE, k[0] ? SMP_MAX : SMP_MIN, 1'b0);
    send_beat(KIND_SAMPLE, SMP_MAX, 1'b1);
    send_beat(KIND_CLEAR, '0, 1'b0);
    drain();

    for (k = 0; k < N_RANDOM; k++) begin
      if (k == 300) hold_req = 1;
      if (k == 700) drain();
      if (k == N_RANDOM - 150) calm = 1;
      idle_gap();
      if ($urandom_range(0, 99) < 2)
        send_beat(KIND_CLEAR, $urandom, 1'($urandom_range(0, 1)));
      else
        send_beat(KIND_SAMPLE, pick_sample(), $urandom_range(0, 99) < 6);
    end
    drain();
    repeat (400) @(posedge clk);
    if (sb.fails == 0 && sb.reports_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
